FILE: hdl/tnb_pkg.sv
package tnb_pkg;

	localparam int TABLE_STEPS = 256;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 32;
	localparam int COEF_FRAC   = COEF_BITS - 4;
	localparam int INDEX_SHIFT = 20;
	localparam int IDX_W       = $clog2(TABLE_STEPS + 1);
	localparam int FREQ_W      = 16;
	localparam int SCALE_W     = 24;
	localparam int ENTRY_W     = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W       = PROD_W + 3;

	localparam logic FUNC_FILTER = 1'b0;
	localparam logic FUNC_WRITE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE = 1'd1;

	localparam logic [FREQ_W-1:0]  FREQ_MIN_RESET   = '0;
	localparam logic [SCALE_W-1:0] FREQ_SCALE_RESET = 24'd65536;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	typedef enum logic {
		OP_FILTER,
		OP_WRITE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MAC,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		coef_t gain;
		coef_t cross_term;
		coef_t feedback;
	} coef_set_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		sample_t          sample;
		coef_set_t        coefs;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hdl/tnb_ifs.sv
interface tnb_item_if;
	import tnb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 func;
	sample_t              sample;
	logic [FREQ_W-1:0]    center_freq;
	logic [ENTRY_W-1:0]   entry_index;
	coef_t                coef_gain;
	coef_t                coef_cross;
	coef_t                coef_feedback;
	modport source (output valid, func, sample, center_freq, entry_index,
		coef_gain, coef_cross, coef_feedback, input ready);
	modport sink (input valid, func, sample, center_freq, entry_index,
		coef_gain, coef_cross, coef_feedback, output ready);
endinterface

interface tnb_result_if;
	import tnb_pkg::*;
	logic    valid;
	logic    ready;
	sample_t filtered;
	modport source (output valid, filtered, input ready);
	modport sink (input valid, filtered, output ready);
endinterface

interface tnb_cfg_if;
	import tnb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tnb_queue.sv
module tnb_queue #(
	parameter int DEPTH = tnb_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tnb_pkg::q_ctrl_t ctrl,
	input  tnb_pkg::cmd_t  push_cmd,
	output tnb_pkg::q_stat_t stat,
	output tnb_pkg::cmd_t  pop_cmd
);
	import tnb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_cmd    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (ctrl.pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push && !ctrl.pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a lone push");
`endif

endmodule

FILE: hdl/tnb_front.sv
module tnb_front (
	input  logic            clk,
	input  logic            arst_n,
	tnb_item_if.sink        items,
	tnb_cfg_if.sink         cfg,
	input  logic            q_full,
	output logic            push,
	output tnb_pkg::cmd_t   push_cmd
);
	import tnb_pkg::*;

	localparam int RAW_W = FREQ_W + SCALE_W - INDEX_SHIFT;

	logic [FREQ_W-1:0]  freq_min_q;
	logic [SCALE_W-1:0] freq_scale_q;

	logic               valid_s1;
	logic               func_s1;
	sample_t            sample_s1;
	logic [FREQ_W-1:0]  freq_s1;
	logic [ENTRY_W-1:0] entry_s1;
	coef_set_t          coefs_s1;

	logic [FREQ_W:0]            diff;
	logic [FREQ_W+SCALE_W-1:0]  prod;
	logic [RAW_W-1:0]           raw_idx;
	logic [IDX_W-1:0]           freq_idx;
	logic                       is_write;
	logic                       entry_ok;
	logic                       drop;
	logic                       leave;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_min_q   <= FREQ_MIN_RESET;
			freq_scale_q <= FREQ_SCALE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FREQ_MIN:   freq_min_q   <= cfg.data[FREQ_W-1:0];
				REG_FREQ_SCALE: freq_scale_q <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// frequency to table index
	always_comb begin
		diff    = {1'b0, freq_s1} - {1'b0, freq_min_q};
		prod    = diff[FREQ_W-1:0] * freq_scale_q;
		raw_idx = prod[FREQ_W+SCALE_W-1:INDEX_SHIFT];
		if (diff[FREQ_W]) begin
			freq_idx = '0;
		end else if (32'(raw_idx) > 32'(TABLE_STEPS)) begin
			freq_idx = IDX_W'(TABLE_STEPS);
		end else begin
			freq_idx = IDX_W'(raw_idx);
		end
	end

	assign is_write = (func_s1 == FUNC_WRITE);
	assign entry_ok = (32'(entry_s1) <= 32'(TABLE_STEPS));
	// out-of-range table writes are dropped here
	assign drop     = is_write && !entry_ok;
	assign leave    = valid_s1 && (drop || !q_full);
	assign push     = valid_s1 && !drop && !q_full;
	assign items.ready = !valid_s1 || leave;

	always_comb begin
		push_cmd.op     = is_write ? OP_WRITE : OP_FILTER;
		push_cmd.idx    = is_write ? IDX_W'(entry_s1) : freq_idx;
		push_cmd.sample = sample_s1;
		push_cmd.coefs  = coefs_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			func_s1             <= items.func;
			sample_s1           <= items.sample;
			freq_s1             <= items.center_freq;
			entry_s1            <= items.entry_index;
			coefs_s1.gain       <= items.coef_gain;
			coefs_s1.cross_term <= items.coef_cross;
			coefs_s1.feedback   <= items.coef_feedback;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> 32'(push_cmd.idx) <= 32'(TABLE_STEPS))
		else $error("queued table index beyond table");
`endif

endmodule

FILE: hdl/tnb_back.sv
module tnb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tnb_pkg::cmd_t     pop_cmd,
	input  logic              q_empty,
	output logic              pop,
	tnb_result_if.source      results
);
	import tnb_pkg::*;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] MAC_LAST = 3'd5;
	localparam logic signed [ACC_W-1:0] RND =
		{{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	coef_set_t coef_mem [TABLE_STEPS+1];
	coef_set_t rd_q;

	back_state_t state_q, state_d;
	logic        load_out;
	logic        mem_we;
	logic        mem_re;

	logic [STEP_W-1:0] step_q;
	sample_t x0_q, p1_q, p2_q, q1_q, q2_q;
	sample_t in_prev1_q, in_prev2_q, out_prev1_q, out_prev2_q;
	logic    primed_q;

	coef_t   coef_sel;
	sample_t samp_sel;
	logic    sub_sel;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  shifted;
	sample_t                  y;

	logic    out_valid_q;
	sample_t out_data_q;

	assign mem_we = pop && (pop_cmd.op == OP_WRITE);
	assign mem_re = pop && (pop_cmd.op == OP_FILTER);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			coef_mem[pop_cmd.idx] <= pop_cmd.coefs;
		end
		if (mem_re) begin
			rd_q <= coef_mem[pop_cmd.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (pop_cmd.op == OP_FILTER) begin
						state_d = BK_MAC;
					end
				end
			end
			BK_MAC: begin
				if (step_q == MAC_LAST) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || results.ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// y = e*x0 - c*x1 + e*x2 + c*y1 - f*y2, one term per step
	always_comb begin
		case (step_q)
			3'd0: begin coef_sel = rd_q.gain;       samp_sel = x0_q; sub_sel = 1'b0; end
			3'd1: begin coef_sel = rd_q.cross_term; samp_sel = p1_q; sub_sel = 1'b1; end
			3'd2: begin coef_sel = rd_q.gain;       samp_sel = p2_q; sub_sel = 1'b0; end
			3'd3: begin coef_sel = rd_q.cross_term; samp_sel = q1_q; sub_sel = 1'b0; end
			3'd4: begin coef_sel = rd_q.feedback;   samp_sel = q2_q; sub_sel = 1'b1; end
			default: begin coef_sel = rd_q.gain;    samp_sel = x0_q; sub_sel = 1'b0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			x0_q <= pop_cmd.sample;
			p1_q <= primed_q ? in_prev1_q  : pop_cmd.sample;
			p2_q <= primed_q ? in_prev2_q  : pop_cmd.sample;
			q1_q <= primed_q ? out_prev1_q : pop_cmd.sample;
			q2_q <= primed_q ? out_prev2_q : pop_cmd.sample;
		end
		if (state_q == BK_MAC) begin
			prod_s1 <= coef_sel * samp_sel;
			sub_s1  <= sub_sel;
			if (step_q == '0) begin
				acc_q <= RND;
			end else if (sub_s1) begin
				acc_q <= acc_q - ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
		if (load_out) begin
			out_data_q <= y;
		end
	end

	always_comb begin
		shifted = acc_q >>> COEF_FRAC;
		if (shifted > SAT_HI) begin
			y = SAMPLE_BITS'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			y = SAMPLE_BITS'(SAT_LO);
		end else begin
			y = SAMPLE_BITS'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			primed_q    <= 1'b0;
			in_prev1_q  <= '0;
			in_prev2_q  <= '0;
			out_prev1_q <= '0;
			out_prev2_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_MAC) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (load_out) begin
				in_prev2_q  <= p1_q;
				in_prev1_q  <= x0_q;
				out_prev2_q <= q1_q;
				out_prev1_q <= y;
				primed_q    <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid    = out_valid_q;
	assign results.filtered = out_data_q;

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MAC) |-> step_q <= MAC_LAST)
		else $error("mac step counter overran");

	a_mac_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MAC && $past(state_q) == BK_IDLE) |-> step_q == '0)
		else $error("mac pass did not start at the first term");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> primed_q && results.valid && state_q != BK_MAC)
		else $error("finished sample not presented");
`endif

endmodule

FILE: hdl/tunable_notch_biquad.sv
// the back end pops a filter transaction in BK_IDLE, walks BK_MAC with the single shared
//   multiplier over the five products, then waits in BK_DONE until the output register has
//   room; no new transaction is popped until then; table writes are stored in BK_IDLE
// the input side keeps accepting while the queue has room
// reset clears control, history and the primed flag; freq_scale resets to 0.0625 (65536 / 2^20);
//   the coefficient table is not cleared and must be loaded before use
module tunable_notch_biquad #(
	parameter int QUEUE_DEPTH = tnb_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	tnb_item_if.sink      items,
	tnb_result_if.source  results,
	tnb_cfg_if.sink       cfg
);
	import tnb_pkg::*;

	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	q_ctrl_t q_ctrl;
	q_stat_t q_stat;

	tnb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cfg      (cfg),
		.q_full   (q_stat.full),
		.push     (q_ctrl.push),
		.push_cmd (push_cmd)
	);

	tnb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.push_cmd (push_cmd),
		.stat     (q_stat),
		.pop_cmd  (pop_cmd)
	);

	tnb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_cmd (pop_cmd),
		.q_empty (q_stat.empty),
		.pop     (q_ctrl.pop),
		.results (results)
	);

endmodule

FILE: dv/tunable_notch_biquad_test.sv
module tunable_notch_biquad_test;
	import tnb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     QUIET_CYCLES = 24;
	localparam longint SAT_HI       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO       = -SAT_HI - 1;

	typedef struct {
		logic               func;
		sample_t            sample;
		logic [FREQ_W-1:0]  cf;
		logic [ENTRY_W-1:0] entry;
		coef_t              gain;
		coef_t              cross_term;
		coef_t              fb;
	} notch_item_t;

	logic clk;
	logic arst_n;

	tnb_item_if   items_if();
	tnb_result_if res_if();
	tnb_cfg_if    cfg_if();

	tunable_notch_biquad DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(res_if),
		.cfg(cfg_if)
	);

	// model of the filter state
	coef_t              gain_mem[0:TABLE_STEPS];
	coef_t              cross_mem[0:TABLE_STEPS];
	coef_t              fb_mem[0:TABLE_STEPS];
	bit                 entry_loaded[0:TABLE_STEPS];
	sample_t            hist_x1, hist_x2, hist_y1, hist_y2;
	bit                 history_primed;
	logic [FREQ_W-1:0]  model_fmin;
	logic [SCALE_W-1:0] model_fscale;

	sample_t pending_filtered[$];
	sample_t want;

	int  errors       = 0;
	int  n_checked    = 0;
	int  n_filter     = 0;
	int  n_loads      = 0;
	int  n_ignored    = 0;
	int  n_settings   = 0;
	int  n_saturated  = 0;
	int  hold_cycles  = 0;
	bit  no_gaps      = 0;
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				pending_filtered.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned table_index(logic [FREQ_W-1:0] cf);
		longint unsigned d;
		longint unsigned idx;
		if (cf < model_fmin)
			return 0;
		d = cf;
		d = d - model_fmin;
		idx = (d * model_fscale) >> INDEX_SHIFT;
		if (idx > TABLE_STEPS)
			idx = TABLE_STEPS;
		return int'(idx);
	endfunction

	function automatic sample_t filter_sample(sample_t x0, int unsigned idx);
		longint g, c, f, v, p1, p2, q1, q2, acc, y;
		g = gain_mem[idx];
		c = cross_mem[idx];
		f = fb_mem[idx];
		v = x0;
		if (history_primed) begin
			p1 = hist_x1;
			p2 = hist_x2;
			q1 = hist_y1;
			q2 = hist_y2;
		end else begin
			p1 = v;
			p2 = v;
			q1 = v;
			q2 = v;
		end
		acc = g * v - c * p1 + g * p2 + c * q1 - f * q2;
		acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
		y = acc >>> COEF_FRAC;
		if (y > SAT_HI) begin
			y = SAT_HI;
			n_saturated++;
		end else if (y < SAT_LO) begin
			y = SAT_LO;
			n_saturated++;
		end
		hist_x2 = p1[SAMPLE_BITS-1:0];
		hist_x1 = x0;
		hist_y2 = q1[SAMPLE_BITS-1:0];
		hist_y1 = y[SAMPLE_BITS-1:0];
		history_primed = 1'b1;
		return y[SAMPLE_BITS-1:0];
	endfunction

	task automatic model_item(input notch_item_t it);
		int unsigned idx;
		if (it.func == FUNC_WRITE) begin
			if (it.entry <= TABLE_STEPS) begin
				gain_mem[it.entry] = it.gain;
				cross_mem[it.entry] = it.cross_term;
				fb_mem[it.entry] = it.fb;
				entry_loaded[it.entry] = 1'b1;
				n_loads++;
			end else begin
				n_ignored++;
			end
		end else begin
			idx = table_index(it.cf);
			pending_filtered.push_back(filter_sample(it.sample, idx));
			n_filter++;
		end
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_filtered.size() == 0) begin
				$error("unexpected transaction, filtered=%0d", res_if.filtered);
				errors++;
			end else begin
				want = pending_filtered.pop_front();
				n_checked++;
				if (res_if.filtered !== want) begin
					$error("filtered: expected %0d, actual %0d", want, res_if.filtered);
					errors++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else if (no_gaps) begin
				res_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				if (stall_left == 0) begin
					res_if.ready <= 1'b1;
				end else begin
					res_if.ready <= 1'b0;
					stall_left--;
				end
			end
		end
	end

	task automatic send_item(input notch_item_t it);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid         <= 1'b1;
		items_if.func          <= it.func;
		items_if.sample        <= it.sample;
		items_if.center_freq   <= it.cf;
		items_if.entry_index   <= it.entry;
		items_if.coef_gain     <= it.gain;
		items_if.coef_cross    <= it.cross_term;
		items_if.coef_feedback <= it.fb;
		do @(posedge clk); while (!items_if.ready);
		model_item(it);
	endtask

	task automatic hold_until_empty();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_filtered.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle_block();
		hold_until_empty();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [FREQ_W-1:0] fmin, input logic [SCALE_W-1:0] fscale);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_FREQ_MIN;
		cfg_if.data  <= CFG_DATA_W'(fmin);
		do @(posedge clk); while (!cfg_if.ready);
		model_fmin = fmin;
		cfg_if.index <= REG_FREQ_SCALE;
		cfg_if.data  <= fscale;
		do @(posedge clk); while (!cfg_if.ready);
		model_fscale = fscale;
		cfg_if.valid <= 1'b0;
		n_settings++;
	endtask

	function automatic notch_item_t table_write(logic [ENTRY_W-1:0] entry, bit wild);
		notch_item_t it;
		longint e, k;
		it.func   = FUNC_WRITE;
		it.sample = sample_t'($urandom);
		it.cf     = FREQ_W'($urandom);
		it.entry  = entry;
		if (wild) begin
			it.gain       = $urandom;
			it.cross_term = $urandom;
			it.fb         = $urandom;
		end else begin
			// stable notch: e in [0.625, 1), cross = 2e*cos
			e = longint'($urandom_range(160, 255)) <<< 20;
			k = longint'($urandom_range(0, 2046)) - 1023;
			it.gain       = coef_t'(e);
			it.cross_term = coef_t'((2 * e * k) / 1024);
			it.fb         = coef_t'(2 * e - (longint'(1) <<< COEF_FRAC));
		end
		return it;
	endfunction

	function automatic notch_item_t coef_write(logic [ENTRY_W-1:0] entry, coef_t g, coef_t c,
		coef_t f);
		notch_item_t it;
		it = table_write(entry, 1'b0);
		it.gain       = g;
		it.cross_term = c;
		it.fb         = f;
		return it;
	endfunction

	function automatic sample_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return sample_t'($urandom);
		if (r < 9)
			return sample_t'(int'($urandom_range(0, 2000)) - 1000);
		return r[0] ? sample_t'(SAT_HI) : sample_t'(SAT_LO);
	endfunction

	function automatic logic [FREQ_W-1:0] rand_cf();
		longint unsigned span, cf;
		if ($urandom_range(0, 1) == 0 || model_fscale == 0)
			return FREQ_W'($urandom_range(0, 65535));
		span = ((longint'(TABLE_STEPS) + 1) << INDEX_SHIFT) / model_fscale;
		if (span > 65535)
			span = 65535;
		cf = model_fmin;
		cf = cf + $urandom_range(0, int'(span));
		return (cf > 65535) ? 16'hFFFF : cf[FREQ_W-1:0];
	endfunction

	task automatic send_filter(input sample_t s, input logic [FREQ_W-1:0] cf);
		notch_item_t it;
		int unsigned idx;
		idx = table_index(cf);
		if (!entry_loaded[idx])
			send_item(table_write(ENTRY_W'(idx), $urandom_range(0, 9) == 0));
		it = table_write(9'd0, 1'b0);
		it.func       = FUNC_FILTER;
		it.sample     = s;
		it.cf         = cf;
		it.entry      = ENTRY_W'($urandom);
		it.gain       = $urandom;
		it.cross_term = $urandom;
		it.fb         = $urandom;
		send_item(it);
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72)
			send_filter(rand_sample(), rand_cf());
		else if (r < 94)
			send_item(table_write(ENTRY_W'($urandom_range(0, TABLE_STEPS)),
				$urandom_range(0, 9) == 0));
		else
			send_item(table_write(ENTRY_W'($urandom_range(TABLE_STEPS + 1, 511)), 1'b1));
	endtask

	// index extremes, out-of-range writes, priming and saturation
	task automatic test_table_edges();
		set_regs(16'd800, 24'h0A0000);
		send_item(table_write(9'd0, 1'b0));
		send_item(table_write(9'd1, 1'b0));
		send_item(table_write(9'd100, 1'b0));
		send_item(table_write(9'd255, 1'b0));
		send_item(coef_write(ENTRY_W'(TABLE_STEPS), 32'h7FFFFFFF, 32'h80000000, 32'h80000000));
		send_item(table_write(9'd257, 1'b1));
		send_item(table_write(9'd511, 1'b1));
		send_filter(sample_t'(SAT_HI), 16'd960);
		send_filter(sample_t'(SAT_LO), 16'd0);
		send_filter(24'sd0, 16'd800);
		send_filter(-24'sd1, 16'd802);
		send_filter(24'sd12345, 16'd1208);
		send_filter(sample_t'(SAT_HI), 16'd1210);
		send_filter(sample_t'(SAT_LO), 16'hFFFF);
		send_filter(sample_t'(SAT_HI), 16'hFFFF);
		send_filter(24'sd1, 16'd960);
		settle_block();
	endtask

	task automatic test_register_sweep();
		logic [FREQ_W-1:0]  fmins[7];
		logic [SCALE_W-1:0] scales[7];
		fmins  = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
		scales = '{24'd65536, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd0};
		for (int i = 4; i < 6; i++) begin
			fmins[i]  = FREQ_W'($urandom_range(0, 65535));
			scales[i] = SCALE_W'($urandom_range(0, 24'hFFFFFF));
		end
		fmins[6]  = FREQ_W'($urandom_range(0, 20000));
		scales[6] = SCALE_W'($urandom_range(1 << 12, 1 << 20));
		foreach (fmins[i]) begin
			settle_block();
			set_regs(fmins[i], scales[i]);
			repeat (35) send_random();
		end
		settle_block();
	endtask

	task automatic test_output_stall();
		set_regs(16'd0, 24'd65536);
		hold_cycles = 400;
		no_gaps = 1'b1;
		repeat (30) send_filter(rand_sample(), rand_cf());
		no_gaps = 1'b0;
	endtask

	task automatic test_sender_pause();
		repeat (12) send_random();
		hold_until_empty();
		repeat (12) send_random();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (40) send_random();
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		items_if.valid         = 1'b0;
		items_if.func          = FUNC_FILTER;
		items_if.sample        = '0;
		items_if.center_freq   = '0;
		items_if.entry_index   = '0;
		items_if.coef_gain     = '0;
		items_if.coef_cross    = '0;
		items_if.coef_feedback = '0;
		res_if.ready           = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.index           = REG_FREQ_MIN;
		cfg_if.data            = '0;
		model_fmin             = FREQ_MIN_RESET;
		model_fscale           = FREQ_SCALE_RESET;
		history_primed         = 1'b0;
		hist_x1                = '0;
		hist_x2                = '0;
		hist_y1                = '0;
		hist_y2                = '0;
		foreach (entry_loaded[i])
			entry_loaded[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_edges();
		test_register_sweep();
		test_output_stall();
		test_sender_pause();
		test_back_to_back();
		settle_block();

		$display("covered %0d filter samples (%0d saturated) and %0d table loads, %0d ignored",
			n_filter, n_saturated, n_loads, n_ignored);
		$display("over %0d register settings; %0d results compared, %0d mismatches",
			n_settings, n_checked, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: tunable_notch_biquad.f
hdl/tnb_pkg.sv
hdl/tnb_ifs.sv
hdl/tnb_queue.sv
hdl/tnb_front.sv
hdl/tnb_back.sv
hdl/tunable_notch_biquad.sv
dv/tunable_notch_biquad_test.sv
